>>> rtl/lra_pkg.sv
// Shared constants, types and state codes for the largest-remainder
// apportionment unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lra_pkg;

  localparam int MAX_LEGS    = 16;
  localparam int MAX_WORKERS = 256;

  localparam int IDX_W    = $clog2(MAX_LEGS);         // leg index
  localparam int CNT_W    = $clog2(MAX_LEGS + 1);     // leg count, holds MAX_LEGS
  localparam int IN_W     = 16;                       // input weight field
  localparam int WEIGHT_W = 17;                       // stored weight
  localparam int TOTAL_W  = 21;                       // weight sum / remainder
  localparam int SHARE_W  = 9;                        // worker count / share
  localparam int QUOT_W   = SHARE_W;                  // quotient never exceeds N
  localparam int PROD_W   = WEIGHT_W + SHARE_W;       // w * N
  localparam int DSR_W    = TOTAL_W + QUOT_W - 1;     // divisor aligned to top quotient bit
  localparam int STEP_W   = $clog2(QUOT_W + 1);

  localparam logic [IN_W-1:0]    ZERO_WEIGHT_VALUE = IN_W'(100);
  localparam logic [SHARE_W-1:0] MAX_WORKERS_V     = SHARE_W'(MAX_WORKERS);

  // sequencer codes
  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_TOP  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_PICK = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  typedef struct packed {
    logic                 done;
    logic [QUOT_W-1:0]    quotient;
    logic [TOTAL_W-1:0]   remainder;
  } div_res_t;

endpackage

`default_nettype wire

>>> rtl/lra_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lra_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lra_pkg::PROD_W-1:0]  dividend,
  input  wire logic [lra_pkg::TOTAL_W-1:0] divisor,
  output lra_pkg::div_res_t                res
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [lra_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [lra_pkg::PROD_W-1:0]   rem_r, rem_nxt;
  logic [lra_pkg::DSR_W-1:0]    dsr_r, dsr_nxt;
  logic [lra_pkg::QUOT_W-1:0]   quo_r, quo_nxt;
  logic                         ge;

  // dividend < divisor * 2^QUOT_W always holds, so the top step starts at QUOT_W-1
  assign ge = lra_pkg::DSR_W'(rem_r) >= dsr_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = dividend;
      dsr_nxt  = lra_pkg::DSR_W'(divisor) << (lra_pkg::QUOT_W - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r[lra_pkg::PROD_W-1:0];
      end
      quo_nxt  = {quo_r[lra_pkg::QUOT_W-2:0], ge};
      dsr_nxt  = dsr_r >> 1;
      step_nxt = step_r + 1'b1;
      if (step_r == lra_pkg::STEP_W'(lra_pkg::QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r[lra_pkg::TOTAL_W-1:0];

endmodule

`default_nettype wire

>>> rtl/largest_remainder_apportion_unit.sv
// Top level of the largest-remainder (Hamilton) apportionment unit:
// weight capture, sequencer, remainder scan and output register.
// Depends on lra_pkg and lra_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// in_       sink       in_valid/in_ready    leg_weight, last_leg
// out_      source     out_valid/out_ready  leg_index, leg_share, overflow, last_result
// cfg_      sink       cfg_valid/cfg_ready  reactor_count
//
// A weight word not marked last keeps the unit loading. The last word starts the plan:
// for each of the L stored legs, a multiply step and a divider run; then up to L-1
// top-up rounds, each a remainder scan over all legs through the single comparator
// and a pick; then the result words, one per cycle while out_ready is high. in_ready
// is low until the last result word sits in the output register. Synchronous active-low reset;
// no clearing pass. cfg_ready is always high.

module largest_remainder_apportion_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [lra_pkg::IN_W-1:0]    in_leg_weight,
  input  wire logic                        in_last_leg,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [3:0]                  out_leg_index,
  output      logic [lra_pkg::SHARE_W-1:0] out_leg_share,
  output      logic                        out_overflow,
  output      logic                        out_last_result,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [lra_pkg::SHARE_W-1:0] cfg_reactor_count
);

  // per-leg stores, each read only at idx_r
  logic [lra_pkg::WEIGHT_W-1:0] wstore_r [lra_pkg::MAX_LEGS];
  logic [lra_pkg::SHARE_W-1:0]  base_r   [lra_pkg::MAX_LEGS];
  logic [lra_pkg::TOTAL_W-1:0]  rem_r    [lra_pkg::MAX_LEGS];

  logic [2:0]                   state_r, state_nxt;
  logic [lra_pkg::SHARE_W-1:0]  rcount_r, rcount_nxt;
  logic [lra_pkg::SHARE_W-1:0]  n_r, n_nxt;
  logic [lra_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic [lra_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [lra_pkg::MAX_LEGS-1:0] topped_r, topped_nxt;
  logic                         drop_r, drop_nxt;
  logic [lra_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [lra_pkg::SHARE_W-1:0]  given_r, given_nxt;
  logic                         found_r, found_nxt;
  logic [lra_pkg::IDX_W-1:0]    pick_r, pick_nxt;
  logic [lra_pkg::TOTAL_W-1:0]  best_r, best_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [3:0]                   out_idx_r, out_idx_nxt;
  logic [lra_pkg::SHARE_W-1:0]  out_share_r, out_share_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         in_acc;
  logic                         store_en;
  logic [lra_pkg::WEIGHT_W-1:0] w_in;
  logic [lra_pkg::SHARE_W-1:0]  n_clamped;
  logic [lra_pkg::IDX_W-1:0]    last_idx;
  logic                         at_last;
  logic                         div_start;
  logic [lra_pkg::PROD_W-1:0]   prod;
  logic                         div_wr;
  logic                         out_load;
  lra_pkg::div_res_t            div_res;

  assign in_ready  = (state_r == lra_pkg::ST_LOAD);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign store_en  = in_acc && (cnt_r < lra_pkg::CNT_W'(lra_pkg::MAX_LEGS));

  // zero weight means the default of 100
  assign w_in = (in_leg_weight == '0) ? lra_pkg::WEIGHT_W'(lra_pkg::ZERO_WEIGHT_VALUE)
                                      : lra_pkg::WEIGHT_W'(in_leg_weight);

  assign n_clamped = (rcount_r > lra_pkg::MAX_WORKERS_V) ? lra_pkg::MAX_WORKERS_V : rcount_r;

  // cnt_r >= 1 whenever a plan runs
  assign last_idx = lra_pkg::IDX_W'(cnt_r - 1'b1);
  assign at_last  = (idx_r == last_idx);

  // single multiplier, result captured in the divider
  assign prod      = lra_pkg::PROD_W'(wstore_r[idx_r]) * lra_pkg::PROD_W'(n_r);
  assign div_start = (state_r == lra_pkg::ST_MUL);
  assign div_wr    = (state_r == lra_pkg::ST_DIV) && div_res.done;

  lra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (total_r),
    .res      (div_res)
  );

  assign out_load = (state_r == lra_pkg::ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    rcount_nxt    = rcount_r;
    n_nxt         = n_r;
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    topped_nxt    = topped_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    given_nxt     = given_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_share_nxt = out_share_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      rcount_nxt = cfg_reactor_count;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lra_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (store_en) begin
            total_nxt = total_r + lra_pkg::TOTAL_W'(w_in);
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_leg) begin
            n_nxt     = n_clamped;
            idx_nxt   = '0;
            given_nxt = '0;
            state_nxt = lra_pkg::ST_MUL;
          end
        end
      end
      lra_pkg::ST_MUL: begin
        state_nxt = lra_pkg::ST_DIV;
      end
      lra_pkg::ST_DIV: begin
        if (div_res.done) begin
          given_nxt = given_r + div_res.quotient;
          if (at_last) begin
            state_nxt = lra_pkg::ST_TOP;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = lra_pkg::ST_MUL;
          end
        end
      end
      lra_pkg::ST_TOP: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = (given_r >= n_r) ? lra_pkg::ST_OUT : lra_pkg::ST_SCAN;
      end
      lra_pkg::ST_SCAN: begin
        // strict compare keeps the lower index on a tie
        if (!topped_r[idx_r] && (!found_r || rem_r[idx_r] > best_r)) begin
          found_nxt = 1'b1;
          pick_nxt  = idx_r;
          best_nxt  = rem_r[idx_r];
        end
        if (at_last) begin
          state_nxt = lra_pkg::ST_PICK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      lra_pkg::ST_PICK: begin
        idx_nxt = '0;
        if (found_r) begin
          topped_nxt[pick_r] = 1'b1;
          given_nxt          = given_r + 1'b1;
          state_nxt          = lra_pkg::ST_TOP;
        end else begin
          state_nxt = lra_pkg::ST_OUT;
        end
      end
      lra_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 4'(idx_r);
          out_share_nxt = base_r[idx_r] + lra_pkg::SHARE_W'(topped_r[idx_r]);
          out_ovf_nxt   = drop_r;
          out_last_nxt  = at_last;
          if (at_last) begin
            // plan done: clear for the next one
            cnt_nxt    = '0;
            total_nxt  = '0;
            topped_nxt = '0;
            drop_nxt   = 1'b0;
            state_nxt  = lra_pkg::ST_LOAD;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lra_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lra_pkg::ST_LOAD;
      rcount_r    <= lra_pkg::SHARE_W'(1);
      total_r     <= '0;
      cnt_r       <= '0;
      topped_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcount_r    <= rcount_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      topped_r    <= topped_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    given_r     <= given_nxt;
    found_r     <= found_nxt;
    pick_r      <= pick_nxt;
    best_r      <= best_nxt;
    out_idx_r   <= out_idx_nxt;
    out_share_r <= out_share_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      wstore_r[cnt_r[lra_pkg::IDX_W-1:0]] <= w_in;
    end
    if (div_wr) begin
      base_r[idx_r] <= div_res.quotient;
      rem_r[idx_r]  <= div_res.remainder;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_leg_index   = out_idx_r;
  assign out_leg_share   = out_share_r;
  assign out_overflow    = out_ovf_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

>>> rtl/lra_chk.sv
// Port-level checker for the apportionment unit, bound to the top level.
// Depends on lra_pkg and largest_remainder_apportion_unit.
`timescale 1ns / 1ps
`default_nettype none

module lra_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_last_leg,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [3:0]                  out_leg_index,
  input wire logic [lra_pkg::SHARE_W-1:0] out_leg_share,
  input wire logic                        out_last_result
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_leg_index) && $stable(out_leg_share))
    else $error("result word changed under stall");

  // a weight word not marked last never starts a plan
  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_leg |=> in_ready)
    else $error("sequencer left load on a non-last word");

  // while loading, only a plan's final result can still be waiting
  a_load_tail: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last_result)
    else $error("mid-plan result pending during load");

  // no share exceeds the worker ceiling
  a_share_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_leg_share <= lra_pkg::MAX_WORKERS_V)
    else $error("share above worker ceiling");

endmodule

bind largest_remainder_apportion_unit lra_chk u_lra_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_leg     (in_last_leg),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_leg_index   (out_leg_index),
  .out_leg_share   (out_leg_share),
  .out_last_result (out_last_result)
);

`default_nettype wire
